[rtl/rau_pkg.sv]
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SUB    = 3'd1;
  localparam logic [2:0] KIND_MUL    = 3'd2;
  localparam logic [2:0] KIND_DIV    = 3'd3;
  localparam logic [2:0] KIND_INV    = 3'd4;
  localparam logic [2:0] KIND_RED    = 3'd5;

  // datapath step commands
  localparam logic [2:0] CMD_IDLE    = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_MUL     = 3'd2;
  localparam logic [2:0] CMD_COMBINE = 3'd3;
  localparam logic [2:0] CMD_GCD     = 3'd4;
  localparam logic [2:0] CMD_DIVIDE  = 3'd5;
  localparam logic [2:0] CMD_FINISH  = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic       div_start;
  } rau_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic rem_zero;
    logic skip_gcd;
  } rau_status_t;

endpackage

[rtl/rau_divider.sv]
// rau_divider: 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on nothing
module rau_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic [6:0]  count;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {remainder, quotient[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        remainder <= trial[63:0];
        quotient  <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= {remainder[62:0], quotient[63]};
        quotient  <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

[rtl/rau_datapath.sv]
// rau_datapath: operand registers, cross products, euclid and reduction
// depends on rau_pkg and rau_divider
module rau_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::rau_cmd_t    cmd,
  output rau_pkg::rau_status_t status,
  input  logic [2:0]           kind,
  input  logic [31:0]          left_num,
  input  logic [31:0]          left_den,
  input  logic [31:0]          right_num,
  input  logic [31:0]          right_den,
  output logic [31:0]          result_num,
  output logic [31:0]          result_den,
  output logic                 overflow,
  output logic                 zero_den
);

  localparam logic [63:0] LIMIT = 64'd1 << (VALUE_WIDTH - 1);

  logic [2:0]  op_kind;
  logic [31:0] ln_m, ld_m, rn_m, rd_m;
  logic        ln_s, ld_s, rn_s, rd_s;
  logic [63:0] p0, p1, p2;
  logic        p0_s, p1_s, p2_s;
  logic [63:0] nmag, dmag, x, y;
  logic        num_s, den_s, neg;
  logic        div_phase;
  logic        div_busy;
  logic [63:0] div_a, div_b, quo, rem;

  // magnitude and sign of one operand taken from its low bits
  function automatic logic [32:0] load_op(input logic [31:0] raw);
    logic [31:0] v;
    logic        s;
    begin
      v = raw << (32 - VALUE_WIDTH);
      v = 32'($signed(v) >>> (32 - VALUE_WIDTH));
      s = v[31];
      load_op = {s, s ? (32'd0 - v) : v};
    end
  endfunction

  function automatic logic [31:0] field(input logic [63:0] bits);
    logic [31:0] v;
    begin
      v = bits[31:0] << (32 - VALUE_WIDTH);
      field = 32'($signed(v) >>> (32 - VALUE_WIDTH));
    end
  endfunction

  // signed-magnitude add of the two cross products, the second one negated for subtract
  logic [63:0] sum_m;
  logic        sum_s, p1_eff;
  always_comb begin
    p1_eff = (op_kind == rau_pkg::KIND_SUB) ? ((p1 != 0) && !p1_s) : p1_s;
    if (p0_s == p1_eff) begin
      sum_m = p0 + p1;
      sum_s = p0_s;
    end else if (p0 >= p1) begin
      sum_m = p0 - p1;
      sum_s = p0_s;
    end else begin
      sum_m = p1 - p0;
      sum_s = p1_eff;
    end
    if (sum_m == 0) sum_s = 1'b0;
  end

  // result sign, never negative zero
  assign neg = (nmag != 64'd0) && (num_s != (den_s && dmag != 64'd0));

  assign div_a = div_phase ? dmag : (cmd.op == rau_pkg::CMD_GCD ? x : nmag);
  assign div_b = (cmd.op == rau_pkg::CMD_GCD) ? y : x;

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(quo), .remainder(rem)
  );

  assign status.div_busy = div_busy;
  assign status.rem_zero = (y == 64'd0);
  assign status.skip_gcd = (x <= 64'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_phase <= 1'b0;
    end else begin
      case (cmd.op)
        rau_pkg::CMD_LOAD: begin
          op_kind <= kind;
          {ln_s, ln_m} <= load_op(left_num);
          {ld_s, ld_m} <= load_op(left_den);
          {rn_s, rn_m} <= load_op(right_num);
          {rd_s, rd_m} <= load_op(right_den);
          div_phase <= 1'b0;
        end
        rau_pkg::CMD_MUL: begin
          case (op_kind)
            rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
              p0 <= ln_m * rd_m; p0_s <= ln_s ^ rd_s;
              p1 <= rn_m * ld_m; p1_s <= rn_s ^ ld_s;
              p2 <= ld_m * rd_m; p2_s <= ld_s ^ rd_s;
            end
            rau_pkg::KIND_MUL: begin
              p0 <= ln_m * rn_m; p0_s <= ln_s ^ rn_s;
              p2 <= ld_m * rd_m; p2_s <= ld_s ^ rd_s;
            end
            rau_pkg::KIND_DIV: begin
              p0 <= ln_m * rd_m; p0_s <= ln_s ^ rd_s;
              p2 <= ld_m * rn_m; p2_s <= ld_s ^ rn_s;
            end
            rau_pkg::KIND_INV: begin
              p0 <= {32'd0, ld_m}; p0_s <= ld_s;
              p2 <= {32'd0, ln_m}; p2_s <= ln_s;
            end
            default: begin
              p0 <= {32'd0, ln_m}; p0_s <= ln_s;
              p2 <= {32'd0, ld_m}; p2_s <= ld_s;
            end
          endcase
        end
        rau_pkg::CMD_COMBINE: begin
          if (op_kind == rau_pkg::KIND_ADD || op_kind == rau_pkg::KIND_SUB) begin
            nmag <= sum_m; num_s <= sum_s;
            x <= sum_m;
          end else begin
            nmag <= p0; num_s <= p0_s;
            x <= p0;
          end
          dmag <= p2; den_s <= p2_s;
          y <= p2;
        end
        rau_pkg::CMD_GCD: begin
          if (!div_busy && !cmd.div_start) begin
            x <= y;
            y <= rem;
          end
        end
        rau_pkg::CMD_DIVIDE: begin
          if (!div_busy && !cmd.div_start) begin
            if (div_phase) dmag <= quo;
            else nmag <= quo;
            div_phase <= ~div_phase;
          end
        end
        rau_pkg::CMD_FINISH: begin
          result_num <= field(neg ? (64'd0 - nmag) : nmag);
          result_den <= field(dmag);
          overflow   <= (dmag >= LIMIT) || (neg ? (nmag > LIMIT) : (nmag >= LIMIT));
          zero_den   <= (dmag == 64'd0);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/rau_ctrl.sv]
// rau_ctrl: sequencer for load, multiply, euclid loop, reduction and output
// depends on rau_pkg
module rau_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rau_pkg::rau_cmd_t    cmd,
  input  rau_pkg::rau_status_t status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_COMB  = 4'd2;
  localparam logic [3:0] S_GTST  = 4'd3;
  localparam logic [3:0] S_GWAIT = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_D2    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic       first, first_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    first_next = first;
    cmd.op = rau_pkg::CMD_IDLE;
    cmd.div_start = 1'b0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = rau_pkg::CMD_LOAD;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = rau_pkg::CMD_MUL;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.op = rau_pkg::CMD_COMBINE;
        state_next = S_GTST;
      end
      S_GTST: begin
        // remainder zero: leave x holding the gcd
        if (status.rem_zero) state_next = S_CHK;
        else begin
          cmd.op = rau_pkg::CMD_GCD;
          cmd.div_start = 1'b1;
          state_next = S_GWAIT;
        end
      end
      S_GWAIT: begin
        cmd.op = rau_pkg::CMD_GCD;
        if (!status.div_busy) state_next = S_GTST;
      end
      S_CHK: begin
        // gcd in x; also covers both-zero case
        if (status.skip_gcd) state_next = S_FIN;
        else begin
          cmd.op = rau_pkg::CMD_DIVIDE;
          cmd.div_start = 1'b1;
          first_next = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        cmd.op = rau_pkg::CMD_DIVIDE;
        if (!status.div_busy) state_next = first ? S_D2 : S_FIN;
      end
      S_D2: begin
        cmd.op = rau_pkg::CMD_DIVIDE;
        cmd.div_start = 1'b1;
        first_next = 1'b0;
        state_next = S_DWAIT;
      end
      S_FIN: begin
        cmd.op = rau_pkg::CMD_FINISH;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

endmodule

[rtl/rational_arith_unit.sv]
// rational_arith_unit: top level of the fraction add/sub/mul/div/invert/reduce unit
// depends on rau_pkg, rau_ctrl, rau_datapath, rau_divider
//
// usage:
//   input channel  in_valid / in_stall carries kind and the two fractions;
//   a beat is taken when in_valid is high and in_stall is low
//   output channel out_valid / out_stall carries result_num, result_den,
//   overflow and zero_den; the result holds while out_stall is high
// sequence:
//   load, cross products and combine, then euclid remainder steps on the
//   shared bit-serial 64-bit divider, then, unless the gcd is 0 or 1, dividing
//   numerator and denominator by the gcd; the total time per item grows
//   with the number of euclid steps
// throughput:
//   one item at a time; in_stall stays high until the result beat is taken
// reset:
//   rst (synchronous) returns the sequencer to idle and drops out_valid
module rational_arith_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] left_num,
  input  logic [31:0] left_den,
  input  logic [31:0] right_num,
  input  logic [31:0] right_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_num,
  output logic [31:0] result_den,
  output logic        overflow,
  output logic        zero_den
);

  rau_pkg::rau_cmd_t    cmd;
  rau_pkg::rau_status_t status;

  // sequencer
  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  // arithmetic
  rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .kind(kind), .left_num(left_num), .left_den(left_den),
    .right_num(right_num), .right_den(right_den),
    .result_num(result_num), .result_den(result_den),
    .overflow(overflow), .zero_den(zero_den)
  );

endmodule

[sim/tb.sv]
// tb: self-checking testbench for rational_arith_unit
// depends on rau_pkg and the rational_arith_unit rtl; runs directed rows, then random beats
// expected results come from an in-bench fraction predictor built on 64-bit magnitudes
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  // kinds not named in the package
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] M_ONE = 32'hffff_ffff;
  localparam int N_RANDOM = 1630;

  // sign/magnitude view of a fraction part
  typedef struct {
    bit          neg;
    bit [63:0]   mag;
  } smag_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        ovf;
    logic        zd;
  } frac_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] ln, ld, rn, rd;
    bit          typed;   // expected result typed into the row
    frac_res_t   res;
  } stim_row_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [2:0]  kind;
  logic [31:0] left_num, left_den, right_num, right_den;
  logic        out_valid, out_stall;
  logic [31:0] result_num, result_den;
  logic        overflow, zero_den;

  frac_res_t   pending_results[$];
  stim_row_t   dir_rows[$];
  int          errs = 0;
  int          phase = 0;      // 0 free, 1 sender gaps, 2 receiver stalls, 3 both
  bit          hold_req = 0;   // asks the receiver for a long hold-off
  int          hold_left = 0;

  rational_arith_unit #(.VALUE_WIDTH(VW)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .left_num(left_num), .left_den(left_den),
    .right_num(right_num), .right_den(right_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_num(result_num), .result_den(result_den),
    .overflow(overflow), .zero_den(zero_den)
  );

  // ---------------- predictor ----------------

  // operand read from its low VW bits, sign-extended, split into sign and magnitude
  function automatic smag_t split_part(logic [31:0] raw);
    bit [63:0] wmask, sbit, v;
    smag_t s;
    wmask = (64'd1 << VW) - 64'd1;
    sbit  = 64'd1 << (VW - 1);
    v = {32'd0, raw} & wmask;
    s.neg = (v & sbit) != 0;
    s.mag = s.neg ? ((~v + 64'd1) & wmask) : v;
    if (s.neg && s.mag == 0) s.mag = sbit;
    return s;
  endfunction

  function automatic smag_t times_part(smag_t a, smag_t b);
    smag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic smag_t plus_part(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  // low VW bits sign-extended to the 32-bit port
  function automatic logic [31:0] pack_field(bit [63:0] bits);
    bit [63:0] wmask, v;
    wmask = (64'd1 << VW) - 64'd1;
    v = bits & wmask;
    if (v & (64'd1 << (VW - 1))) v = v | ~wmask;
    return v[31:0];
  endfunction

  function automatic frac_res_t reduce_fraction(logic [2:0] k, logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c, logic [31:0] d);
    smag_t ln, ld, rn, rd, num, den;
    bit [63:0] x, y, t, nmag, dmag, lim;
    bit neg, ovf;
    frac_res_t r;
    ln = split_part(a); ld = split_part(b);
    rn = split_part(c); rd = split_part(d);
    case (k)
      rau_pkg::KIND_ADD: begin
        num = plus_part(times_part(ln, rd), times_part(rn, ld));
        den = times_part(ld, rd);
      end
      rau_pkg::KIND_SUB: begin
        rn.neg = (rn.mag != 0) && !rn.neg;
        num = plus_part(times_part(ln, rd), times_part(rn, ld));
        den = times_part(ld, rd);
      end
      rau_pkg::KIND_MUL: begin
        num = times_part(ln, rn);
        den = times_part(ld, rd);
      end
      rau_pkg::KIND_DIV: begin
        num = times_part(ln, rd);
        den = times_part(ld, rn);
      end
      rau_pkg::KIND_INV: begin
        num = ld;
        den = ln;
      end
      default: begin  // reduce, and the spare kinds act the same
        num = ln;
        den = ld;
      end
    endcase
    nmag = num.mag;
    dmag = den.mag;
    neg = (nmag != 0) && (num.neg != (den.neg && dmag != 0));
    if (nmag != 0 || dmag != 0) begin
      x = nmag; y = dmag;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x > 1) begin
        nmag = nmag / x;
        dmag = dmag / x;
      end
    end
    lim = 64'd1 << (VW - 1);
    ovf = (dmag >= lim) || (neg ? (nmag > lim) : (nmag >= lim));
    r.num = pack_field(neg ? (64'd0 - nmag) : nmag);
    r.den = pack_field(dmag);
    r.ovf = ovf;
    r.zd  = (dmag == 0);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic void add_row(logic [2:0] k, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d, bit typed,
                                  logic [31:0] en, logic [31:0] ed, logic eo, logic ez);
    stim_row_t row;
    row.kind = k; row.ln = a; row.ld = b; row.rn = c; row.rd = d;
    row.typed = typed;
    row.res.num = en; row.res.den = ed; row.res.ovf = eo; row.res.zd = ez;
    dir_rows.push_back(row);
  endfunction

  // mostly small operands keep euclid short; some full range and corner values
  function automatic logic [31:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'd0;
          1: return 32'd1;
          2: return M_ONE;
          3: return S_MIN;
          default: return S_MAX;
        endcase
      end
      1, 2: return $urandom;
      3: return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // ---------------- clock, reset, limit ----------------

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // generous ceiling: worst euclid chains plus long stalls on every beat
  initial begin
    #2_000_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------- result side ----------------

  // beats are checked against the oldest pending result; stall pattern follows the phase
  always @(posedge clk) begin
    frac_res_t e;
    int pct;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: num %h den %h", result_num, result_den);
          errs++;
        end else begin
          e = pending_results.pop_front();
          if (result_num !== e.num) begin
            $error("result_num expected %h got %h", e.num, result_num); errs++;
          end
          if (result_den !== e.den) begin
            $error("result_den expected %h got %h", e.den, result_den); errs++;
          end
          if (overflow !== e.ovf) begin
            $error("overflow expected %b got %b", e.ovf, overflow); errs++;
          end
          if (zero_den !== e.zd) begin
            $error("zero_den expected %b got %b", e.zd, zero_den); errs++;
          end
        end
      end
      // long hold-off so the unit backs up and holds its input stalled
      if (hold_req && hold_left == 0) begin
        hold_left <= 3000;
        out_stall <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (hold_left == 1) hold_left <= 0;
        pct = (phase == 2) ? 54 : (phase == 3) ? 22 : 0;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // ---------------- input side ----------------

  task automatic send_beat(logic [2:0] k, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d, bit typed, frac_res_t tres);
    int pct;
    pct = (phase == 1) ? 54 : (phase == 3) ? 22 : 0;
    // idle gaps before the beat
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    left_num  <= a;
    left_den  <= b;
    right_num <= c;
    right_den <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(typed ? tres : reduce_fraction(k, a, b, c, d));
  endtask

  initial begin
    frac_res_t none;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    left_num = '0; left_den = '0; right_num = '0; right_den = '0;
    none = '{num: '0, den: '0, ovf: 1'b0, zd: 1'b0};

    // directed rows; typed expectations only where obvious
    add_row(rau_pkg::KIND_RED, 32'd6,  32'd4,  32'd0, 32'd0, 1, 32'd3, 32'd2, 0, 0);
    add_row(rau_pkg::KIND_RED, 32'd0,  32'd5,  32'd0, 32'd0, 1, 32'd0, 32'd1, 0, 0);
    add_row(rau_pkg::KIND_RED, -32'd7, 32'd0,  32'd0, 32'd0, 1, M_ONE, 32'd0, 0, 1);
    add_row(rau_pkg::KIND_RED, 32'd9,  32'd0,  32'd0, 32'd0, 1, 32'd1, 32'd0, 0, 1);
    add_row(rau_pkg::KIND_RED, 32'd0,  32'd0,  32'd0, 32'd0, 1, 32'd0, 32'd0, 0, 1);
    add_row(rau_pkg::KIND_RED, S_MIN,  M_ONE,  32'd0, 32'd0, 1, S_MIN, 32'd1, 1, 0);
    add_row(rau_pkg::KIND_RED, 32'd4,  -32'd6, 32'd0, 32'd0, 1, -32'd2, 32'd3, 0, 0);
    add_row(rau_pkg::KIND_INV, 32'd3,  32'd7,  32'd0, 32'd0, 1, 32'd7, 32'd3, 0, 0);
    add_row(rau_pkg::KIND_INV, 32'd0,  32'd7,  32'd0, 32'd0, 1, 32'd1, 32'd0, 0, 1);
    add_row(KIND_SPARE6, 32'd10, 32'd15, 32'd0, 32'd0, 1, 32'd2, 32'd3, 0, 0);
    add_row(KIND_SPARE7, -32'd8, 32'd12, S_MAX, S_MIN, 1, -32'd2, 32'd3, 0, 0);
    add_row(rau_pkg::KIND_ADD, 32'd1,  32'd2,  32'd1, 32'd3, 1, 32'd5, 32'd6, 0, 0);
    add_row(rau_pkg::KIND_SUB, 32'd1,  32'd2,  32'd1, 32'd2, 1, 32'd0, 32'd1, 0, 0);
    add_row(rau_pkg::KIND_MUL, 32'd2,  32'd3,  32'd3, 32'd4, 1, 32'd1, 32'd2, 0, 0);
    add_row(rau_pkg::KIND_DIV, 32'd1,  32'd2,  32'd1, 32'd4, 1, 32'd2, 32'd1, 0, 0);
    add_row(rau_pkg::KIND_DIV, 32'd1,  32'd2,  32'd0, 32'd4, 1, 32'd1, 32'd0, 0, 1);
    add_row(rau_pkg::KIND_MUL, S_MIN,  32'd1,  S_MIN, 32'd1, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_ADD, S_MAX,  32'd1,  S_MAX, 32'd1, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_SUB, S_MIN,  32'd1,  S_MAX, 32'd1, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_ADD, S_MAX,  S_MIN,  M_ONE, S_MAX, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_DIV, S_MIN,  S_MAX,  S_MAX, S_MIN, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_SUB, M_ONE,  M_ONE,  S_MIN, M_ONE, 0, '0, '0, 0, 0);
    add_row(rau_pkg::KIND_MUL, 32'hffff_0000, 32'h0000_ffff, 32'h5555_5555, 32'haaaa_aaaa,
            0, '0, '0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].ln, dir_rows[i].ld, dir_rows[i].rn,
                dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].res);

    for (n = 0; n < N_RANDOM; n++) begin
      phase = (n / 150) % 4;
      if (n == 400) hold_req = 1;
      if (n == 402) hold_req = 0;
      if (n == 800) begin
        // pause the sender until the unit has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_beat(3'($urandom_range(0, 7)), pick_operand(), pick_operand(), pick_operand(),
                pick_operand(), 0, none);
    end
    in_valid <= 1'b0;
    phase = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
sim/tb.sv
